### src/jlfs_pkg.sv
// Shared types, constants and scaling functions for the joystick link frame supervisor.
package jlfs_pkg;

  // Frame markers and fixed frame bytes
  localparam logic [7:0] FRAME_START = 8'hAB;
  localparam logic [7:0] FRAME_STOP  = 8'hCD;
  localparam logic [7:0] HS_BYTE1    = 8'h11;
  localparam logic [7:0] HS_BYTE2    = 8'h22;
  localparam logic [7:0] HS_BYTE3    = 8'h33;
  localparam logic [7:0] HS_BYTE4    = 8'h44;

  // Reply payload codes
  localparam logic [7:0] HS_REPLY    = 8'h04;
  localparam logic [7:0] ACK_BYTE1   = 8'h01;
  localparam logic [7:0] ACK_BYTE2   = 8'h23;
  localparam logic [7:0] ACK_BYTE3   = 8'h45;
  localparam logic [7:0] ACK_BYTE4   = 8'h67;
  localparam logic [7:0] RECON_BYTE  = 8'h0F;

  localparam logic [12:0] AXIS_CENTRE = 13'd2047;
  localparam logic [4:0]  COUNT_MAX   = 5'd31;

  // Byte positions within a frame
  localparam logic [2:0] FIRST_BYTE = 3'd0;
  localparam logic [2:0] LAST_BYTE  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_DEAD_ZONE     = 2'd0;
  localparam logic [1:0] REG_FAIL_LIMIT    = 2'd1;
  localparam logic [1:0] REG_RECON_PENALTY = 2'd2;

  // Configuration reset values
  localparam logic [10:0] DEAD_ZONE_RST     = 11'd800;
  localparam logic [4:0]  FAIL_LIMIT_RST    = 5'd6;
  localparam logic [4:0]  RECON_PENALTY_RST = 5'd10;

  // Reciprocal scaling: (205*m + 500) / 1650 and (155*m - 250) / 1250,
  // each folded into one constant multiply, an offset and a shift by 30.
  localparam logic [39:0] X_GAIN = 40'd133404365;
  localparam logic [39:0] X_BIAS = 40'd325376500;
  localparam logic [39:0] Y_GAIN = 40'd133144070;
  localparam logic [39:0] Y_BIAS = 40'd214748500;

  typedef struct packed {
    logic [11:0] x_raw;
    logic [11:0] y_raw;
    logic        reply_ready;
    logic [7:0]  reply_b0;
    logic [7:0]  reply_b1;
    logic [7:0]  reply_b2;
    logic [7:0]  reply_b3;
    logic [7:0]  reply_b4;
    logic [7:0]  reply_b5;
    logic        link_closed;
  } item_t;

  typedef struct packed {
    logic [10:0] dead_zone;
    logic [4:0]  fail_limit;
    logic [4:0]  reconnect_penalty;
  } cfg_t;

  typedef struct packed {
    logic       connected;
    logic [4:0] fail_count;
  } link_state_t;

  typedef struct packed {
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic       link_up;
    logic       relink;
  } frame_t;

  // x byte from magnitude, magnitude at most 2048
  function automatic logic [7:0] x_scale(input logic [11:0] m);
    logic [39:0] p;
    p = {28'd0, m} * X_GAIN + X_BIAS;
    return p[37:30];
  endfunction

  // y byte from magnitude, zero where the numerator would go negative
  function automatic logic [7:0] y_scale(input logic [11:0] m);
    logic [39:0] p;
    p = {28'd0, m} * Y_GAIN - Y_BIAS;
    if (m < 12'd2) begin
      return 8'd0;
    end
    return p[37:30];
  endfunction

endpackage

### src/jlfs_eval.sv
// Frame contents and next link state for one loop pass.
module jlfs_eval (
  input  jlfs_pkg::item_t       item,
  input  jlfs_pkg::cfg_t        cfg,
  input  jlfs_pkg::link_state_t state,
  output jlfs_pkg::link_state_t state_next,
  output jlfs_pkg::frame_t      frame
);
  import jlfs_pkg::*;

  logic        x_pos, x_neg, y_pos, y_neg;
  logic [11:0] x_mag, y_mag;
  logic [7:0]  x_byte, y_byte;
  logic        hs_ok, data_ok, ack, recon;
  logic [4:0]  inc;
  logic [5:0]  sum;
  logic [4:0]  count_next;
  logic        drop;

  // Classify each axis against the dead zone
  always_comb begin
    x_pos = {1'b0, item.x_raw} > (AXIS_CENTRE + {2'b0, cfg.dead_zone});
    x_neg = ({1'b0, item.x_raw} + {2'b0, cfg.dead_zone}) < AXIS_CENTRE;
    y_pos = {1'b0, item.y_raw} > (AXIS_CENTRE + {2'b0, cfg.dead_zone});
    y_neg = ({1'b0, item.y_raw} + {2'b0, cfg.dead_zone}) < AXIS_CENTRE;
    x_mag = x_pos ? item.x_raw - AXIS_CENTRE[11:0] : AXIS_CENTRE[11:0] - item.x_raw;
    y_mag = y_pos ? item.y_raw - AXIS_CENTRE[11:0] : AXIS_CENTRE[11:0] - item.y_raw;
    x_byte = x_scale(x_mag);
    y_byte = y_scale(y_mag);
  end

  // Decode the reply
  always_comb begin
    hs_ok = item.reply_ready && item.reply_b0 == FRAME_START &&
            item.reply_b1 == HS_REPLY && item.reply_b2 == HS_REPLY &&
            item.reply_b3 == HS_REPLY && item.reply_b4 == HS_REPLY &&
            item.reply_b5 == FRAME_STOP;
    data_ok = item.reply_ready && item.reply_b0 == FRAME_START;
    ack = data_ok && item.reply_b1 == ACK_BYTE1 && item.reply_b2 == ACK_BYTE2 &&
          item.reply_b3 == ACK_BYTE3 && item.reply_b4 == ACK_BYTE4;
    recon = data_ok && item.reply_b1 == RECON_BYTE && item.reply_b2 == RECON_BYTE &&
            item.reply_b3 == RECON_BYTE && item.reply_b4 == RECON_BYTE;
  end

  // Saturating fail counter update and drop decision
  always_comb begin
    inc = recon ? cfg.reconnect_penalty : 5'd1;
    sum = {1'b0, state.fail_count} + {1'b0, inc};
    if (ack) begin
      count_next = 5'd0;
    end else if (sum[5]) begin
      count_next = COUNT_MAX;
    end else begin
      count_next = sum[4:0];
    end
    drop = count_next > cfg.fail_limit;
  end

  // Assemble frame and next state
  always_comb begin
    if (!state.connected) begin
      frame.b1             = HS_BYTE1;
      frame.b2             = HS_BYTE2;
      frame.b3             = HS_BYTE3;
      frame.b4             = HS_BYTE4;
      state_next.connected  = hs_ok;
      state_next.fail_count = state.fail_count;
      frame.relink          = 1'b0;
    end else begin
      frame.b1             = x_pos ? x_byte : 8'd0;
      frame.b2             = (!x_pos && x_neg) ? x_byte : 8'd0;
      frame.b3             = (!y_pos && y_neg) ? y_byte : 8'd0;
      frame.b4             = y_pos ? y_byte : 8'd0;
      state_next.connected  = !drop;
      state_next.fail_count = count_next;
      frame.relink          = drop && item.link_closed;
    end
    frame.link_up = state_next.connected;
  end

endmodule

### src/jlfs_tx.sv
// Frame register and byte serializer for the outgoing six-byte frame.
module jlfs_tx (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             load_ready,
  input  jlfs_pkg::frame_t frame_in,
  output logic             byte_valid,
  input  logic             byte_stall,
  output logic [7:0]       tx_byte,
  output logic             frame_end,
  output logic             link_up,
  output logic             relink
);
  import jlfs_pkg::*;

  frame_t     frame;
  logic       full;
  logic [2:0] pos;
  logic       take;
  logic       last_take;

  assign take       = full && !byte_stall;
  assign last_take  = take && pos == LAST_BYTE;
  assign load_ready = !full || last_take;

  // Hold the frame and advance through its bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      pos  <= FIRST_BYTE;
    end else begin
      if (load_valid && load_ready) begin
        full <= 1'b1;
        pos  <= FIRST_BYTE;
      end else if (last_take) begin
        full <= 1'b0;
        pos  <= FIRST_BYTE;
      end else if (take) begin
        pos <= pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      frame <= frame_in;
    end
  end

  // Select the current byte
  always_comb begin
    case (pos)
      3'd0:    tx_byte = FRAME_START;
      3'd1:    tx_byte = frame.b1;
      3'd2:    tx_byte = frame.b2;
      3'd3:    tx_byte = frame.b3;
      3'd4:    tx_byte = frame.b4;
      default: tx_byte = FRAME_STOP;
    endcase
  end

  assign byte_valid = full;
  assign frame_end  = pos == LAST_BYTE;
  assign link_up    = frame.link_up;
  assign relink     = frame.relink;

endmodule

### src/joystick_link_frame_supervisor.sv
// Top level: item register, configuration, link state and frame output.
// The frame register sends each frame out one byte at a time; the first byte is
// offered once the frame register takes the item from the item register. The
// byte-wide output channel limits the item rate (an item may wait in the input
// register while the previous frame drains).
// Reset (rst, synchronous): link down, fail count zero, registers at
// dead_zone 800, fail_limit 6, reconnect_penalty 10, both channels empty.
module joystick_link_frame_supervisor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [11:0] x_raw,
  input  logic [11:0] y_raw,
  input  logic        reply_ready,
  input  logic [7:0]  reply_b0,
  input  logic [7:0]  reply_b1,
  input  logic [7:0]  reply_b2,
  input  logic [7:0]  reply_b3,
  input  logic [7:0]  reply_b4,
  input  logic [7:0]  reply_b5,
  input  logic        link_closed,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  tx_byte,
  output logic        frame_end,
  output logic        link_up,
  output logic        relink
);
  import jlfs_pkg::*;

  cfg_t        cfg;
  link_state_t state;
  link_state_t state_next;
  item_t       item;
  logic        item_full;
  logic        tx_ready;
  logic        move;
  frame_t      frame_next;

  assign cfg_ready  = 1'b1;
  assign move       = item_full && tx_ready;
  assign item_stall = item_full && !tx_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone         <= DEAD_ZONE_RST;
      cfg.fail_limit        <= FAIL_LIMIT_RST;
      cfg.reconnect_penalty <= RECON_PENALTY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEAD_ZONE:     cfg.dead_zone         <= cfg_data;
        REG_FAIL_LIMIT:    cfg.fail_limit        <= cfg_data[4:0];
        REG_RECON_PENALTY: cfg.reconnect_penalty <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted item until the frame register takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_full <= 1'b1;
    end else if (move) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item <= '{x_raw: x_raw, y_raw: y_raw, reply_ready: reply_ready,
                reply_b0: reply_b0, reply_b1: reply_b1, reply_b2: reply_b2,
                reply_b3: reply_b3, reply_b4: reply_b4, reply_b5: reply_b5,
                link_closed: link_closed};
    end
  end

  // Advance link state once per transaction moved to the frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.connected  <= 1'b0;
      state.fail_count <= 5'd0;
    end else if (move) begin
      state <= state_next;
    end
  end

  jlfs_eval u_eval (
    .item       (item),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .frame      (frame_next)
  );

  jlfs_tx u_tx (
    .clk        (clk),
    .rst        (rst),
    .load_valid (item_full),
    .load_ready (tx_ready),
    .frame_in   (frame_next),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .tx_byte    (tx_byte),
    .frame_end  (frame_end),
    .link_up    (link_up),
    .relink     (relink)
  );

  // A frame goes out without gaps once started
  a_frame_continues: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && !frame_end |=> byte_valid)
    else $error("frame interrupted before its last byte");

  // The last byte is always the stop marker
  a_stop_marker: assert property (@(posedge clk) disable iff (rst)
    byte_valid && frame_end |-> tx_byte == FRAME_STOP)
    else $error("last frame byte is not the stop marker");

  // A reconnect request only comes with the link down
  a_relink_down: assert property (@(posedge clk) disable iff (rst)
    byte_valid && relink |-> !link_up)
    else $error("relink raised while link is up");

  // Link state changes only when an item moves to the frame register
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !move |=> $stable(state))
    else $error("link state changed without an item");

endmodule

### tb/joystick_link_frame_supervisor_tb.sv
// Self-checking testbench for the joystick link frame supervisor: directed table, then random phases.
module joystick_link_frame_supervisor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jlfs_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Reply patterns, first byte in the top bits
  localparam logic [47:0] HS_OK    = {FRAME_START, {4{HS_REPLY}}, FRAME_STOP};
  localparam logic [47:0] ACK_OK   = {FRAME_START, ACK_BYTE1, ACK_BYTE2, ACK_BYTE3,
                                      ACK_BYTE4, 8'h00};
  localparam logic [47:0] RECON_RQ = {FRAME_START, {4{RECON_BYTE}}, 8'h00};
  localparam logic [47:0] SILENT   = 48'h0;

  typedef struct {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       link_up;
    logic       relink;
  } frame_byte_t;

  typedef struct {
    bit          is_reg;
    item_t       it;
    bit          typed;
    frame_t      want;
    logic [1:0]  idx;
    logic [10:0] val;
  } plan_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [11:0] x_raw = '0;
  logic [11:0] y_raw = '0;
  logic        reply_ready = 1'b0;
  logic [7:0]  reply_b0 = '0;
  logic [7:0]  reply_b1 = '0;
  logic [7:0]  reply_b2 = '0;
  logic [7:0]  reply_b3 = '0;
  logic [7:0]  reply_b4 = '0;
  logic [7:0]  reply_b5 = '0;
  logic        link_closed = 1'b0;
  logic        byte_valid;
  logic        byte_stall = 1'b0;
  logic [7:0]  tx_byte;
  logic        frame_end;
  logic        link_up;
  logic        relink;

  // Predicted link state and register copies
  bit linked;
  int fail_cnt;
  int dz_set = int'(DEAD_ZONE_RST);
  int limit_set = int'(FAIL_LIMIT_RST);
  int penalty_set = int'(RECON_PENALTY_RST);

  frame_byte_t frame_bytes_due[$];
  plan_row_t   plan[$];
  int idle_pct;
  int stall_pct;
  int errors;
  int passes;
  int drops;
  int reg_writes;

  joystick_link_frame_supervisor uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .x_raw(x_raw), .y_raw(y_raw), .reply_ready(reply_ready),
    .reply_b0(reply_b0), .reply_b1(reply_b1), .reply_b2(reply_b2),
    .reply_b3(reply_b3), .reply_b4(reply_b4), .reply_b5(reply_b5),
    .link_closed(link_closed),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .tx_byte(tx_byte), .frame_end(frame_end), .link_up(link_up), .relink(relink)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic item_t itm(input int x, input int y, input logic rdy,
                                input logic [47:0] reply, input logic cl);
    return {x[11:0], y[11:0], rdy, reply, cl};
  endfunction

  function automatic frame_t fr(input logic [7:0] b1, input logic [7:0] b2,
                                input logic [7:0] b3, input logic [7:0] b4,
                                input logic up, input logic rl);
    return {b1, b2, b3, b4, up, rl};
  endfunction

  // Direction byte levels from the centred magnitude
  function automatic logic [7:0] x_level(input int m);
    return 8'((205 * m + 500) / 1650);
  endfunction

  function automatic logic [7:0] y_level(input int m);
    int n;
    n = 155 * m - 250;
    return (n < 0) ? 8'd0 : 8'(n / 1250);
  endfunction

  task automatic queue_frame(input frame_t f);
    frame_byte_t fb;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: fb.tx_byte = FRAME_START;
        1: fb.tx_byte = f.b1;
        2: fb.tx_byte = f.b2;
        3: fb.tx_byte = f.b3;
        4: fb.tx_byte = f.b4;
        default: fb.tx_byte = FRAME_STOP;
      endcase
      fb.frame_end = (k == 5);
      fb.link_up = f.link_up;
      fb.relink = f.relink;
      frame_bytes_due.push_back(fb);
    end
  endtask

  // One supervisor pass: advance link state, optionally queue the frame
  task automatic run_link_pass(input item_t it, input bit queue_it);
    frame_t f;
    int a;
    int b;
    f = '0;
    if (!linked) begin
      f.b1 = HS_BYTE1;
      f.b2 = HS_BYTE2;
      f.b3 = HS_BYTE3;
      f.b4 = HS_BYTE4;
      if (it.reply_ready && {it.reply_b0, it.reply_b1, it.reply_b2, it.reply_b3,
                             it.reply_b4, it.reply_b5} == HS_OK)
        linked = 1'b1;
    end else begin
      a = int'(it.x_raw) - int'(AXIS_CENTRE);
      b = int'(it.y_raw) - int'(AXIS_CENTRE);
      if (a > dz_set) f.b1 = x_level(a);
      else if (a < -dz_set) f.b2 = x_level(-a);
      if (b > dz_set) f.b4 = y_level(b);
      else if (b < -dz_set) f.b3 = y_level(-b);
      // Score the reply
      if (it.reply_ready && it.reply_b0 == FRAME_START) begin
        if ({it.reply_b1, it.reply_b2, it.reply_b3, it.reply_b4} == ACK_OK[39:8])
          fail_cnt = 0;
        else if ({it.reply_b1, it.reply_b2, it.reply_b3, it.reply_b4} == RECON_RQ[39:8])
          fail_cnt = fail_cnt + penalty_set;
        else
          fail_cnt = fail_cnt + 1;
      end else begin
        fail_cnt = fail_cnt + 1;
      end
      if (fail_cnt > int'(COUNT_MAX)) fail_cnt = int'(COUNT_MAX);
      if (fail_cnt > limit_set) begin
        linked = 1'b0;
        f.relink = it.link_closed;
        drops++;
      end
    end
    f.link_up = linked;
    passes++;
    if (queue_it) queue_frame(f);
  endtask

  // Offer one pass; hold it until the block takes it
  task automatic offer_pass(input item_t it, input bit typed, input frame_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    {x_raw, y_raw, reply_ready, reply_b0, reply_b1, reply_b2, reply_b3, reply_b4, reply_b5,
     link_closed} <= it;
    do @(posedge clk); while (item_stall);
    run_link_pass(it, !typed);
    if (typed) queue_frame(want);
  endtask

  // Write a register once every frame has drained
  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    item_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEAD_ZONE:     dz_set = int'(val);
      REG_FAIL_LIMIT:    limit_set = int'(val[4:0]);
      REG_RECON_PENALTY: penalty_set = int'(val[4:0]);
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic plan_item(input item_t it);
    plan_row_t r;
    r = '{default: '0};
    r.it = it;
    plan.push_back(r);
  endtask

  task automatic plan_typed(input item_t it, input frame_t want);
    plan_row_t r;
    r = '{default: '0};
    r.it = it;
    r.typed = 1'b1;
    r.want = want;
    plan.push_back(r);
  endtask

  task automatic plan_reg(input logic [1:0] idx, input logic [10:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.idx = idx;
    r.val = val;
    plan.push_back(r);
  endtask

  // Axis sample biased toward the rails, the centre and the dead-zone edges
  function automatic logic [11:0] axis_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 4095;
      2: v = 2047;
      3, 4, 5: begin
        v = dz_set + $urandom_range(0, 3) - 1;
        v = $urandom_range(0, 1) ? 2047 + v : 2047 - v;
      end
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  // Mostly well-formed replies for the current link state, some damaged, some noise
  function automatic item_t gen_pass();
    item_t it;
    logic [63:0] noise;
    logic [47:0] rb;
    int pick;
    noise = {$urandom, $urandom};
    rb = noise[47:0];
    pick = $urandom_range(0, 99);
    if (!linked) begin
      if (pick < 75) rb = HS_OK;
    end else if (pick < 55) begin
      rb = ACK_OK;
      rb[7:0] = noise[55:48];
    end else if (pick < 72) begin
      rb = RECON_RQ;
      rb[7:0] = noise[55:48];
    end else if (pick < 85) begin
      rb[47:40] = FRAME_START;
    end
    if (pick >= 45 && pick < 75) rb[$urandom_range(0, 47)] ^= 1'b1;
    return itm(int'(axis_sample()), int'(axis_sample()), $urandom_range(0, 9) != 0, rb,
               1'($urandom_range(0, 1)));
  endfunction

  // Check results, drive random backpressure
  always @(posedge clk) begin
    frame_byte_t exp_b;
    if (!rst && byte_valid === 1'b1 && !byte_stall) begin
      if (frame_bytes_due.size() == 0) begin
        $error("unexpected frame byte %h with nothing pending", tx_byte);
        errors++;
      end else begin
        exp_b = frame_bytes_due.pop_front();
        if (tx_byte !== exp_b.tx_byte) begin
          $error("tx_byte expected %h actual %h", exp_b.tx_byte, tx_byte);
          errors++;
        end
        if (frame_end !== exp_b.frame_end) begin
          $error("frame_end expected %b actual %b", exp_b.frame_end, frame_end);
          errors++;
        end
        if (link_up !== exp_b.link_up) begin
          $error("link_up expected %b actual %b", exp_b.link_up, link_up);
          errors++;
        end
        if (relink !== exp_b.relink) begin
          $error("relink expected %b actual %b", exp_b.relink, relink);
          errors++;
        end
      end
    end
    byte_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    int dz;
    int lim;
    int pen;
    int directed;
    frame_t hs_down;
    frame_t hs_up;
    hs_down = fr(HS_BYTE1, HS_BYTE2, HS_BYTE3, HS_BYTE4, 1'b0, 1'b0);
    hs_up = fr(HS_BYTE1, HS_BYTE2, HS_BYTE3, HS_BYTE4, 1'b1, 1'b0);

    // Directed table at reset settings
    plan_typed(itm(2047, 2047, 1'b0, SILENT, 1'b0), hs_down);
    plan_typed(itm(2047, 2047, 1'b1, {HS_OK[47:8], 8'hCC}, 1'b0), hs_down);
    plan_typed(itm(2047, 2047, 1'b0, HS_OK, 1'b0), hs_down);
    plan_typed(itm(2047, 2047, 1'b1, HS_OK, 1'b1), hs_up);
    plan_typed(itm(4095, 0, 1'b1, ACK_OK, 1'b0), fr(8'd254, 8'd0, 8'd253, 8'd0, 1'b1, 1'b0));
    plan_typed(itm(0, 4095, 1'b1, ACK_OK, 1'b1), fr(8'd0, 8'd254, 8'd0, 8'd253, 1'b1, 1'b0));
    plan_typed(itm(2047, 2047, 1'b1, ACK_OK, 1'b0), fr(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
    plan_item(itm(2847, 1247, 1'b1, ACK_OK, 1'b0));
    plan_item(itm(2848, 1246, 1'b1, ACK_OK, 1'b0));
    plan_item(itm(1246, 2848, 1'b1, {8'hAA, ACK_OK[39:0]}, 1'b0));
    plan_item(itm(1247, 2847, 1'b1, {ACK_OK[47:16], 8'h66, 8'hFF}, 1'b1));
    plan_item(itm(3000, 1000, 1'b1, ACK_OK, 1'b0));
    plan_typed(itm(2047, 2047, 1'b1, RECON_RQ, 1'b1), fr(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
    plan_typed(itm(4095, 4095, 1'b1, HS_OK, 1'b1), hs_up);
    // Counter survived the drop: one miss drops the link again
    plan_typed(itm(2047, 2047, 1'b0, ACK_OK, 1'b0), fr(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    plan_typed(itm(0, 0, 1'b1, HS_OK, 1'b0), hs_up);
    plan_item(itm(1500, 2600, 1'b1, ACK_OK, 1'b0));
    // Limit at the counter ceiling: saturate, never drop
    plan_reg(REG_FAIL_LIMIT, 11'd31);
    plan_reg(REG_RECON_PENALTY, 11'd31);
    plan_typed(itm(2047, 2047, 1'b1, RECON_RQ, 1'b0), fr(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
    plan_typed(itm(2047, 2047, 1'b1, RECON_RQ, 1'b1), fr(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
    plan_typed(itm(2047, 2047, 1'b0, SILENT, 1'b1), fr(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
    // Zero dead zone, zero limit and penalty, plus the spare index
    plan_reg(REG_DEAD_ZONE, 11'd0);
    plan_reg(REG_FAIL_LIMIT, 11'd0);
    plan_reg(REG_RECON_PENALTY, 11'd0);
    plan_reg(REG_UNUSED, 11'h7FF);
    plan_item(itm(2048, 2046, 1'b1, ACK_OK, 1'b0));
    plan_item(itm(2046, 2048, 1'b1, RECON_RQ, 1'b0));
    plan_item(itm(2047, 2049, 1'b0, SILENT, 1'b0));
    plan_reg(REG_DEAD_ZONE, 11'd2047);
    plan_typed(itm(2047, 2047, 1'b1, HS_OK, 1'b0), hs_up);
    plan_item(itm(4095, 0, 1'b1, ACK_OK, 1'b0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the table
    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].idx, plan[i].val);
      else offer_pass(plan[i].it, plan[i].typed, plan[i].want);
    end
    directed = passes;

    // Random phases: each rewrites all registers and changes the idling pattern
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin dz = 0; lim = 0; pen = 0; end
        1: begin dz = 2047; lim = 31; pen = 31; end
        2: begin
          dz = $urandom_range(0, 2047);
          lim = $urandom_range(1, 8);
          pen = $urandom_range(0, 31);
        end
        3: begin
          dz = int'(DEAD_ZONE_RST);
          lim = int'(FAIL_LIMIT_RST);
          pen = int'(RECON_PENALTY_RST);
        end
        default: begin
          dz = $urandom_range(0, 2047);
          lim = $urandom_range(0, 31);
          pen = $urandom_range(0, 31);
        end
      endcase
      write_reg(REG_DEAD_ZONE, dz[10:0]);
      write_reg(REG_FAIL_LIMIT, {6'($urandom), lim[4:0]});
      write_reg(REG_RECON_PENALTY, {6'($urandom), pen[4:0]});
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 55; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 55; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      repeat (64) offer_pass(gen_pass(), 1'b0, '0);
    end

    // Drain, then let trailing cycles expose stray bytes
    item_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Ran %0d passes (%0d from the directed table), %0d register writes, %0d link drops.",
             passes, directed, reg_writes, drops);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
